@@ rtl/kts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg: shared types and codes of the keyed task serializer
// Opcodes, status codes, sizes and the front-to-back command record.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_SUBMIT_KEYED = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;
  localparam logic [1:0] OP_DONE = 2'd3;

  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_PARKED = 3'd1;
  localparam logic [2:0] ST_REJ_STOP = 3'd2;
  localparam logic [2:0] ST_REJ_FULL = 3'd3;
  localparam logic [2:0] ST_DISPATCHED = 3'd4;
  localparam logic [2:0] ST_NONE_READY = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;
  localparam logic [2:0] ST_PROMOTED = 3'd7;

  localparam int unsigned OWNER_W = 6;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned IN_FLIGHT_MAX = 1023;

  // queue sizes; all powers of two so pointer wrap is a plain carry-out
  localparam int unsigned OWNER_COUNT  = 64;
  localparam int unsigned READY_DEPTH  = 256;
  localparam int unsigned PARKED_DEPTH = 8;
  localparam int unsigned TAG_BITS     = 16;

  // decoded item passed from the front end to the execution engine
  typedef struct packed {
    logic [1:0]         opcode;
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
    logic               was_keyed;
    logic               stop;
  } kts_cmd_t;

endpackage

@@ rtl/kts_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_front: input stage and command queue
// Unpacks incoming items, captures the stop flag, and buffers them in a
// two-entry queue toward the execution engine.
// ----------------------------------------------------------------------------
module kts_front
  import kts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      stop_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [OWNER_W-1:0] owner_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic               was_keyed_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output kts_cmd_t  cmd_o
);

  kts_cmd_t  q_mem_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  kts_cmd_t  c;
  logic      push, pop;

  always_comb begin
    c.opcode    = opcode_i;
    c.owner     = OWNER_W'(32'(owner_i) % OWNER_COUNT);
    c.tag       = tag_i;
    c.was_keyed = was_keyed_i;
    c.stop      = stop_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/kts_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_back: execution engine
// Four-state sequencer: the accept cycle reads the ready head and the
// owner's queue pointers, a read cycle fetches the parked head, an update
// cycle writes state and loads the result register, which is then held
// until taken.
// ----------------------------------------------------------------------------
module kts_back
  import kts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  kts_cmd_t cmd_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] out_tag_o,
  output logic [5:0]  out_owner_o,
  output logic        out_keyed_o,
  output logic [8:0]  ready_depth_o,
  output logic [8:0]  ready_high_mark_o,
  output logic [31:0] submitted_count_o,
  output logic [31:0] completed_count_o,
  output logic [6:0]  busy_owners_o,
  output logic [9:0]  parked_total_o,
  output logic [9:0]  in_flight_o
);

  localparam int unsigned OW  = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
  localparam int unsigned RW  = $clog2(READY_DEPTH);
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned PW  = (PARKED_DEPTH > 1) ? $clog2(PARKED_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(PARKED_DEPTH + 1);
  localparam int unsigned EW  = TAG_BITS + OW + 1;
  localparam int unsigned PKW = $clog2(OWNER_COUNT * PARKED_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q;

  // memories
  logic [EW-1:0]       rq_mem [READY_DEPTH];
  logic [TAG_BITS-1:0] pk_mem [OWNER_COUNT * PARKED_DEPTH];
  logic [PW+PCW-1:0]   pk_ptr_mem [OWNER_COUNT];  // {head, count}
  logic [OWNER_COUNT-1:0] pk_vld_q;  // pointer entry written since reset
  logic [OWNER_COUNT-1:0] busy_q;

  logic [EW-1:0]       rq_rd_q;
  logic [TAG_BITS-1:0] pk_rd_q;
  logic [PW+PCW-1:0]   pk_ptr_rd_q;
  kts_cmd_t            cmd_q;

  logic [RW-1:0]  rq_head_q, rq_tail_q;
  logic [RCW-1:0] rq_cnt_q;
  logic [8:0]     high_q;
  logic [31:0]    sub_q, comp_q;
  logic [6:0]     busy_n_q;
  logic [PKW-1:0] pk_total_q;
  logic [9:0]     infl_q;

  logic [2:0]  st_q;
  logic [15:0] otag_q;
  logic [5:0]  oown_q;
  logic        okey_q;

  logic [OW-1:0]  own, cown;
  logic           owner_busy;
  logic           rq_full, pk_full;
  logic [PW-1:0]  pk_head, slot;
  logic [PCW-1:0] pk_cnt;
  logic [OW+PW-1:0] pk_addr_rd;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign own  = cmd_i.owner[OW-1:0];
  assign cown = cmd_q.owner[OW-1:0];

  // unwritten pointer entries read as an empty queue
  always_comb begin
    pk_head = pk_vld_q[cown] ? pk_ptr_rd_q[PW+PCW-1:PCW] : '0;
    pk_cnt  = pk_vld_q[cown] ? pk_ptr_rd_q[PCW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q       <= cmd_i;
      rq_rd_q     <= rq_mem[rq_head_q];
      pk_ptr_rd_q <= pk_ptr_mem[own];
    end
    if (state_q == S_READ) begin
      pk_rd_q <= pk_mem[{cown, pk_head}];
    end
  end

  always_comb begin
    owner_busy = busy_q[cown];
    rq_full    = (rq_cnt_q == RCW'(READY_DEPTH));
    pk_full    = (pk_cnt == PCW'(PARKED_DEPTH));
    slot       = PW'((32'(pk_head) + 32'(pk_cnt)) % PARKED_DEPTH);
    pk_addr_rd = {cown, slot};
  end

  logic do_push, do_pop, do_park, do_promote, set_busy, clr_busy;
  logic [EW-1:0] push_e;
  logic [2:0] st_d;
  logic [PW-1:0]  ptr_head_d;
  logic [PCW-1:0] ptr_cnt_d;

  always_comb begin
    do_push = 1'b0; do_pop = 1'b0; do_park = 1'b0; do_promote = 1'b0;
    set_busy = 1'b0; clr_busy = 1'b0;
    push_e = '0;
    st_d = ST_RELEASED;
    unique case (cmd_q.opcode)
      OP_SUBMIT, OP_SUBMIT_KEYED: begin
        if (cmd_q.stop) begin
          st_d = ST_REJ_STOP;
        end else if (cmd_q.opcode == OP_SUBMIT || !owner_busy) begin
          if (rq_full) begin
            st_d = ST_REJ_FULL;
          end else begin
            do_push  = 1'b1;
            set_busy = (cmd_q.opcode == OP_SUBMIT_KEYED);
            push_e   = {TAG_BITS'(cmd_q.tag), set_busy ? cown : OW'(0), set_busy};
            st_d     = ST_QUEUED;
          end
        end else if (pk_full) begin
          st_d = ST_REJ_FULL;
        end else begin
          do_park = 1'b1;
          st_d    = ST_PARKED;
        end
      end
      OP_DISPATCH: begin
        if (rq_cnt_q == '0) begin
          st_d = ST_NONE_READY;
        end else begin
          do_pop = 1'b1;
          st_d   = ST_DISPATCHED;
        end
      end
      default: begin
        if (cmd_q.was_keyed && owner_busy) begin
          if (pk_cnt != '0) begin
            if (rq_full) begin
              st_d = ST_REJ_FULL;
            end else begin
              do_promote = 1'b1;
              do_push    = 1'b1;
              push_e     = {pk_rd_q, cown, 1'b1};
              st_d       = ST_PROMOTED;
            end
          end else begin
            clr_busy = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    ptr_head_d = do_promote ? PW'((32'(pk_head) + 32'd1) % PARKED_DEPTH) : pk_head;
    ptr_cnt_d  = do_park ? pk_cnt + PCW'(1) : pk_cnt - PCW'(1);
  end

  logic [RCW-1:0] rq_cnt_d;
  assign rq_cnt_d = rq_cnt_q + RCW'(do_push) - RCW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      if (do_push) rq_mem[rq_tail_q] <= push_e;
      if (do_park) pk_mem[pk_addr_rd] <= TAG_BITS'(cmd_q.tag);
      if (do_park || do_promote) pk_ptr_mem[cown] <= {ptr_head_d, ptr_cnt_d};
      st_q   <= st_d;
      otag_q <= do_pop ? 16'(rq_rd_q[EW-1 -: TAG_BITS]) : 16'd0;
      oown_q <= (do_pop && rq_rd_q[0]) ? 6'(rq_rd_q[OW:1]) : 6'd0;
      okey_q <= do_pop && rq_rd_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rq_head_q <= '0; rq_tail_q <= '0; rq_cnt_q <= '0;
      high_q <= '0; sub_q <= '0; comp_q <= '0;
      busy_q <= '0; busy_n_q <= '0; pk_total_q <= '0; infl_q <= '0;
      pk_vld_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) state_q <= S_READ;
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= S_OUT;
          if (do_push) rq_tail_q <= RW'((32'(rq_tail_q) + 32'd1) % READY_DEPTH);
          if (do_pop)  rq_head_q <= RW'((32'(rq_head_q) + 32'd1) % READY_DEPTH);
          rq_cnt_q <= rq_cnt_d;
          if (32'(rq_cnt_d) > 32'(high_q)) high_q <= 9'(rq_cnt_d);
          if ((do_push && !do_promote) || do_park) sub_q <= sub_q + 32'd1;
          if (cmd_q.opcode == OP_DONE) begin
            comp_q <= comp_q + 32'd1;
            if (infl_q != '0) infl_q <= infl_q - 10'd1;
          end
          if (do_pop && infl_q != 10'(IN_FLIGHT_MAX)) infl_q <= infl_q + 10'd1;
          if (set_busy) begin
            busy_q[cown] <= 1'b1;
            busy_n_q <= busy_n_q + 7'd1;
          end
          if (clr_busy) begin
            busy_q[cown] <= 1'b0;
            busy_n_q <= busy_n_q - 7'd1;
          end
          if (do_park || do_promote) pk_vld_q[cown] <= 1'b1;
          if (do_park) pk_total_q <= pk_total_q + PKW'(1);
          if (do_promote) pk_total_q <= pk_total_q - PKW'(1);
        end
        S_OUT: if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o       = (state_q == S_OUT);
  assign status_o          = st_q;
  assign out_tag_o         = otag_q;
  assign out_owner_o       = oown_q;
  assign out_keyed_o       = okey_q;
  assign ready_depth_o     = 9'(rq_cnt_q);
  assign ready_high_mark_o = high_q;
  assign submitted_count_o = sub_q;
  assign completed_count_o = comp_q;
  assign busy_owners_o     = busy_n_q;
  assign parked_total_o    = 10'(pk_total_q);
  assign in_flight_o       = infl_q;

endmodule

@@ rtl/keyed_task_serializer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_task_serializer_top: per-owner serialized task queue
// The execution engine works through each item in steps: accept with ready-head
// and owner-pointer read, parked-head read, update, and result hold until
// taken; it takes the next item the cycle after its result is taken, so it
// does not take a new item before it is through with the last. A two-entry
// command queue lets the input side run ahead by two items. The ready queue
// and the owner queues are memories.
// ----------------------------------------------------------------------------
module keyed_task_serializer_top
  import kts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  // owner_id[5:0], task_tag[21:6], was_keyed[22], zero pad
  input  logic [23:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  // out_tag[15:0], out_owner[21:16], out_keyed[22], ready_depth[31:23],
  // ready_high_mark[40:32], submitted_count[72:41], completed_count[104:73],
  // busy_owners[111:105], parked_total[121:112], in_flight[131:122],
  // zero pad
  output logic [135:0] m_axis_tdata
);

  logic     stop_q;
  logic     cmd_valid, cmd_ready;
  kts_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
    end else if (cfg_we_i) begin
      stop_q <= cfg_wdata_i;
    end
  end

  kts_front u_front (
    .clk_i, .rst_ni, .stop_i(stop_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .owner_i(s_axis_tdata[5:0]),
    .tag_i(s_axis_tdata[21:6] & 16'((17'd1 << TAG_BITS) - 17'd1)),
    .was_keyed_i(s_axis_tdata[22]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  kts_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(m_axis_tuser), .out_tag_o(m_axis_tdata[15:0]),
    .out_owner_o(m_axis_tdata[21:16]), .out_keyed_o(m_axis_tdata[22]),
    .ready_depth_o(m_axis_tdata[31:23]), .ready_high_mark_o(m_axis_tdata[40:32]),
    .submitted_count_o(m_axis_tdata[72:41]), .completed_count_o(m_axis_tdata[104:73]),
    .busy_owners_o(m_axis_tdata[111:105]), .parked_total_o(m_axis_tdata[121:112]),
    .in_flight_o(m_axis_tdata[131:122])
  );

  assign m_axis_tdata[135:132] = 4'd0;

endmodule

@@ rtl/kts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_checker: port-level checks
// Output hold under stall and consistency of reported fields.
// ----------------------------------------------------------------------------
module kts_checker
  import kts_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [2:0]   m_axis_tuser,
  input logic [135:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DISPATCHED |-> m_axis_tdata[22:0] == '0)
    else $error("task fields set without dispatch");

  a_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[40:32] >= m_axis_tdata[31:23])
    else $error("high mark below depth");

  a_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[22] |-> m_axis_tdata[21:16] == '0)
    else $error("owner set on unkeyed task");

endmodule

bind keyed_task_serializer_top kts_checker u_kts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
  .m_axis_tdata(m_axis_tdata)
);
